### hw/rtl/sss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  localparam int unsigned ValueW   = 14;
  localparam int unsigned BaseW    = 8;
  localparam int unsigned DwellW   = 10;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigit = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [ValueW-1:0] MaxValue  = ValueW'(9999);
  localparam logic [BaseW-1:0]  BaseReset = BaseW'(20);

  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_FOUR
  } kind_e;

  typedef struct packed {
    kind_e                            kind;
    logic [NumDigit-1:0][DigitW-1:0] digits;
  } qentry_t;

  function automatic logic [7:0] dec99(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 15'(x) * 15'd205;
    t = p[14:11];
    o = x - 7'(t) * 7'd10;
    return {t, o[3:0]};
  endfunction

  function automatic logic [7:0] seg7(input logic [DigitW-1:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] dsel(input logic [1:0] pos);
    logic [7:0] s;
    case (pos)
      2'd0:    s = 8'h7F;
      2'd1:    s = 8'hBF;
      2'd2:    s = 8'hDF;
      default: s = 8'hEF;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sss_front import sss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [ValueW-1:0] in_value_i,
  output      logic              push_o,
  input  wire logic              full_i,
  output      qentry_t           entry_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [ValueW-1:0] v_q, v_d;
  logic [6:0]        hi_q, hi_d;
  logic [ValueW-1:0] v_sat;
  logic [26:0]       prod;
  logic [ValueW-1:0] lo_full;
  logic [7:0]        hi_dec, lo_dec;
  logic              load;

  assign v_sat = (in_value_i > MaxValue) ? MaxValue : in_value_i;
  assign prod  = 27'(v_sat) * 27'd5243;

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_o) s1_valid_d = 1'b0;
    if (load)   s1_valid_d = 1'b1;
    v_d  = load ? v_sat : v_q;
    hi_d = load ? prod[25:19] : hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    hi_q <= hi_d;
  end

  assign lo_full = v_q - ValueW'(hi_q) * ValueW'(100);
  assign hi_dec  = dec99(hi_q);
  assign lo_dec  = dec99(lo_full[6:0]);

  always_comb begin
    entry_o.digits[0] = lo_dec[3:0];
    entry_o.digits[1] = lo_dec[7:4];
    entry_o.digits[2] = hi_dec[3:0];
    entry_o.digits[3] = hi_dec[7:4];
    if (v_q < ValueW'(10)) begin
      entry_o.kind = KIND_ONE;
    end else if (v_q < ValueW'(100)) begin
      entry_o.kind = KIND_TWO;
    end else if (v_q < ValueW'(1000)) begin
      entry_o.kind = KIND_THREE;
    end else begin
      entry_o.kind = KIND_FOUR;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sss_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sss_fifo import sss_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire qentry_t wdata_i,
  output      logic    full_o,
  input  wire logic    pop_i,
  output      logic    empty_o,
  output      qentry_t rdata_o
);

  qentry_t          mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

### hw/rtl/sss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sss_back import sss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [BaseW-1:0] base_i,
  input  wire logic             empty_i,
  input  wire qentry_t          entry_i,
  output      logic             pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [7:0]       out_select_o,
  output      logic [7:0]       out_segments_o,
  output      logic [DwellW-1:0] out_dwell_o,
  output      logic             out_last_o
);

  logic [IdxW-1:0]   idx_q, idx_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        sel_q, sel_d;
  logic [7:0]        seg_q, seg_d;
  logic [DwellW-1:0] dwell_q, dwell_d;
  logic              last_q, last_d;
  logic              emit;
  logic [1:0]        pos;
  logic              is_last;
  logic [15:0]       p3;
  logic [DwellW-1:0] dwell;

  assign emit = !empty_i && (!ovalid_q || out_ready_i);
  assign pop_o = emit && is_last;
  assign p3 = 16'(base_i) * 16'd171;

  always_comb begin
    dwell = DwellW'(base_i);
    case (entry_i.kind)
      KIND_ONE: begin
        pos     = 2'd0;
        is_last = 1'b1;
        dwell   = {base_i, 2'b00};
      end
      KIND_TWO: begin
        pos     = {1'b0, idx_q[0]};
        is_last = (idx_q == IdxW'(3));
      end
      KIND_THREE: begin
        pos     = (idx_q >= IdxW'(3)) ? 2'(idx_q - IdxW'(3)) : idx_q[1:0];
        is_last = (idx_q == IdxW'(5));
        if (idx_q >= IdxW'(3)) dwell = DwellW'(p3[15:9]);
      end
      default: begin
        pos     = idx_q[1:0];
        is_last = (idx_q == IdxW'(3));
      end
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    sel_d    = sel_q;
    seg_d    = seg_q;
    dwell_d  = dwell_q;
    last_d   = last_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (emit) begin
      ovalid_d = 1'b1;
      idx_d    = is_last ? '0 : idx_q + 1'b1;
      sel_d    = dsel(pos);
      seg_d    = seg7(entry_i.digits[pos]);
      dwell_d  = dwell;
      last_d   = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q   <= sel_d;
    seg_q   <= seg_d;
    dwell_q <= dwell_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = ovalid_q;
  assign out_select_o   = sel_q;
  assign out_segments_o = seg_q;
  assign out_dwell_o    = dwell_q;
  assign out_last_o     = last_q;

endmodule

`default_nettype wire

### hw/rtl/seven_segment_scan_sequencer.sv
// Inputs pass the front register, the queue and the back-end output registers in order.
// Throughput: one result per cycle unless the queue is empty or the master stalls; a number
// gives 1, 4, 6 or 4 results by digit count (under 10, under 100, under 1000, otherwise),
// set by the back-end scan counter. Inputs overlap the previous scan via a 2-entry queue.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue and sets dwell_base to 20.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_sequencer import sss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [13:0] value
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [7:0] digit_select, [15:8] segments,
                                           // [25:16] dwell_ms
  output      logic        m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  logic [BaseW-1:0]  base_q, base_d;
  logic              push, full, pop, empty;
  qentry_t           wentry, rentry;
  logic [7:0]        sel, seg;
  logic [DwellW-1:0] dwell;

  assign base_d = cfg_we_i ? cfg_wdata_i : base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else begin
      base_q <= base_d;
    end
  end

  sss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata[ValueW-1:0]),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (wentry)
  );

  sss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rentry)
  );

  sss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_i         (base_q),
    .empty_i        (empty),
    .entry_i        (rentry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_select_o   (sel),
    .out_segments_o (seg),
    .out_dwell_o    (dwell),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, dwell, seg, sel};

endmodule

`default_nettype wire

### hw/rtl/sss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_we_i,
  input wire logic [7:0]  cfg_wdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_select_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:0] == 8'h7F || m_axis_tdata[7:0] == 8'hBF
      || m_axis_tdata[7:0] == 8'hDF || m_axis_tdata[7:0] == 8'hEF)
    else $error("digit select not one-cold");

  a_no_dp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[15] && m_axis_tdata[31:26] == 6'b0)
    else $error("decimal point or pad bits set");

  a_thousands_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:0] == 8'hEF |-> m_axis_tlast)
    else $error("thousands digit not last");

endmodule

bind seven_segment_scan_sequencer sss_checker u_sss_checker (.*);

`default_nettype wire
